// ----- hdl/amr_b2o_pkg.sv -----
// Shared types, constants and frame-type tables for the AMR bandwidth-efficient
// to octet-aligned converter. Depends on nothing; the converter modules and the testbench import it.
package amr_b2o_pkg;

	localparam int BUFFER_BYTES_DEFAULT = 256;
	localparam logic [8:0] OSL_RESET = 9'd256;
	localparam logic [3:0] FT_MAX_SPEECH = 4'd11;
	localparam logic [3:0] FT_NO_DATA = 4'd15;
	localparam logic [5:0] HDR_ONLY_BYTES = 6'd2;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [5:0] out_length;
		logic       error;
		logic       last_of_frame;
	} res_t;

	// Results produced by one input word: count is 0, 1 or 2, r0 goes first.
	typedef struct packed {
		logic [1:0] count;
		res_t       r0;
		res_t       r1;
	} push_t;

	function automatic logic [7:0] speech_bits(input logic [3:0] ft);
		logic [7:0] b;
		case (ft)
			4'd0: b = 8'd95;
			4'd1: b = 8'd103;
			4'd2: b = 8'd118;
			4'd3: b = 8'd134;
			4'd4: b = 8'd148;
			4'd5: b = 8'd159;
			4'd6: b = 8'd204;
			4'd7: b = 8'd244;
			4'd8: b = 8'd39;
			4'd9: b = 8'd43;
			4'd10: b = 8'd38;
			4'd11: b = 8'd37;
			default: b = 8'd0;
		endcase
		return b;
	endfunction

	// Input bytes that carry the 10 header bits plus the speech bits.
	function automatic logic [5:0] needed_in(input logic [3:0] ft);
		logic [8:0] t;
		t = 9'd17 + {1'b0, speech_bits(ft)};
		return t[8:3];
	endfunction

	function automatic logic [5:0] speech_bytes(input logic [3:0] ft);
		logic [8:0] t;
		t = 9'd7 + {1'b0, speech_bits(ft)};
		return t[8:3];
	endfunction

	// Zero padding bits in the last speech byte.
	function automatic logic [2:0] pad_bits(input logic [3:0] ft);
		logic [7:0] b;
		b = speech_bits(ft);
		return 3'd0 - b[2:0];
	endfunction

endpackage

// ----- hdl/amr_b2o_if.sv -----
// Handshake channel interfaces: input words, result words and the
// configuration write channel. Depends on nothing.
interface amr_b2o_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic [7:0] frame_length;
	logic       last_byte;

	modport source(output valid, output data_byte, output frame_length, output last_byte,
		input ready);
	modport sink(input valid, input data_byte, input frame_length, input last_byte,
		output ready);
endinterface

interface amr_b2o_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [5:0] out_length;
	logic       error;
	logic       last_of_frame;

	modport source(output valid, output out_byte, output out_length, output error,
		output last_of_frame, input ready);
	modport sink(input valid, input out_byte, input out_length, input error,
		input last_of_frame, output ready);
endinterface

interface amr_b2o_cfg_if;
	logic       valid;
	logic       ready;
	logic [8:0] output_space_limit;

	modport source(output valid, output output_space_limit, input ready);
	modport sink(input valid, input output_space_limit, output ready);
endinterface

// ----- hdl/amr_b2o_conv.sv -----
// Frame parser and bit realigner: holds the per-frame state and turns one
// registered input word into zero, one or two result words. Depends on amr_b2o_pkg.
module amr_b2o_conv #(
	parameter int BUFFER_BYTES = amr_b2o_pkg::BUFFER_BYTES_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          data_byte,
	input  logic [7:0]          frame_length,
	input  logic                last_byte,
	input  logic [8:0]          osl,
	output amr_b2o_pkg::push_t  push
);
	import amr_b2o_pkg::*;

	logic [7:0] idx_q, idx_d;
	logic [7:0] prev_q, prev_d;
	logic [3:0] ft_q, ft_d;
	logic [5:0] rlen_q, rlen_d;
	logic       disc_q, disc_d;
	logic       done_q, done_d;

	logic [3:0] ft_new;
	logic [5:0] req_new;
	logic [5:0] rlen_new;
	logic [8:0] fl_p1;
	logic       over_buf;
	logic       hdr_bad;
	logic [5:0] req_q;
	logic [2:0] pad_q;
	logic [7:0] mask_q;
	logic       early;
	logic [7:0] merged;
	res_t       err_res;

	assign ft_new   = {prev_q[2:0], data_byte[7]};
	assign req_new  = needed_in(ft_new);
	assign rlen_new = HDR_ONLY_BYTES + speech_bytes(ft_new);
	assign fl_p1    = {1'b0, frame_length} + 9'd1;
	assign over_buf = 32'(fl_p1) > BUFFER_BYTES;
	assign hdr_bad  = (frame_length < 8'd2) || (fl_p1 > osl) || over_buf
		|| ((ft_new > FT_MAX_SPEECH) && (ft_new != FT_NO_DATA))
		|| ({2'b00, req_new} > frame_length)
		|| (last_byte && (req_new > HDR_ONLY_BYTES));

	assign req_q  = needed_in(ft_q);
	assign pad_q  = pad_bits(ft_q);
	assign mask_q = 8'hFF << pad_q;
	assign early  = ({1'b0, idx_q} + 9'd1) < {3'b000, req_q};
	assign merged = {prev_q[5:0], data_byte[7:6]};
	assign err_res = '{out_byte: 8'd0, out_length: 6'd0, error: 1'b1, last_of_frame: 1'b1};

	always_comb begin
		logic take_err;
		logic take_fin;
		logic take_new;
		take_err = 1'b0;
		take_fin = 1'b0;
		take_new = 1'b0;
		push   = '0;
		idx_d  = idx_q;
		prev_d = prev_q;
		ft_d   = ft_q;
		rlen_d = rlen_q;
		disc_d = disc_q;
		done_d = done_q;

		if (disc_q || done_q) begin
			take_new = last_byte;
		end else if (idx_q == 8'd0) begin
			if (last_byte) begin
				take_err = 1'b1;
			end else begin
				prev_d = data_byte;
				idx_d  = 8'd1;
			end
		end else if (idx_q == 8'd1) begin
			if (hdr_bad) begin
				take_err = 1'b1;
			end else begin
				ft_d   = ft_new;
				rlen_d = rlen_new;
				push.count = 2'd2;
				push.r0 = '{out_byte: {prev_q[7:4], 4'b0000}, out_length: rlen_new,
					error: 1'b0, last_of_frame: 1'b0};
				push.r1 = '{out_byte: {prev_q[3], ft_new, data_byte[6], 2'b00},
					out_length: rlen_new, error: 1'b0,
					last_of_frame: req_new == HDR_ONLY_BYTES};
				prev_d = data_byte;
				idx_d  = 8'd2;
				take_fin = req_new == HDR_ONLY_BYTES;
			end
		end else begin
			if (early && last_byte) begin
				take_err = 1'b1;
			end else if (early) begin
				push.count = 2'd1;
				push.r0 = '{out_byte: merged, out_length: rlen_q, error: 1'b0,
					last_of_frame: 1'b0};
				prev_d = data_byte;
				if (idx_q != 8'hFF) begin
					idx_d = idx_q + 8'd1;
				end
			end else if (pad_q >= 3'd2) begin
				// The final speech byte needs no bits from a further input byte.
				push.count = 2'd2;
				push.r0 = '{out_byte: merged, out_length: rlen_q, error: 1'b0,
					last_of_frame: 1'b0};
				push.r1 = '{out_byte: {data_byte[5:0], 2'b00} & mask_q, out_length: rlen_q,
					error: 1'b0, last_of_frame: 1'b1};
				take_fin = 1'b1;
			end else begin
				push.count = 2'd1;
				push.r0 = '{out_byte: merged & mask_q, out_length: rlen_q, error: 1'b0,
					last_of_frame: 1'b1};
				take_fin = 1'b1;
			end
		end

		if (take_err) begin
			push.count = 2'd1;
			push.r0 = err_res;
			if (last_byte) begin
				take_new = 1'b1;
			end else begin
				disc_d = 1'b1;
			end
		end
		if (take_fin) begin
			if (last_byte) begin
				take_new = 1'b1;
			end else begin
				done_d = 1'b1;
			end
		end
		if (take_new) begin
			idx_d  = 8'd0;
			prev_d = 8'd0;
			disc_d = 1'b0;
			done_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			prev_q <= '0;
			ft_q   <= '0;
			rlen_q <= '0;
			disc_q <= 1'b0;
			done_q <= 1'b0;
		end else if (step) begin
			idx_q  <= idx_d;
			prev_q <= prev_d;
			ft_q   <= ft_d;
			rlen_q <= rlen_d;
			disc_q <= disc_d;
			done_q <= done_d;
		end
	end

endmodule

// ----- hdl/amr_b2o_obuf.sv -----
// Four-entry result queue: takes up to two result words per cycle while it has room and hands
// one out per cycle while the sink takes it. Depends on amr_b2o_pkg.
module amr_b2o_obuf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_en,
	input  amr_b2o_pkg::push_t push,
	input  logic               pop,
	output logic               room,
	output logic               valid,
	output amr_b2o_pkg::res_t  head
);
	import amr_b2o_pkg::*;

	res_t       mem_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] count_q;
	logic [1:0] n_push;
	logic [1:0] wr_next;

	assign n_push  = push_en ? push.count : 2'd0;
	assign wr_next = wr_q + 2'd1;
	// Room for two more words whatever the sink does this cycle.
	assign room  = count_q <= 3'd2;
	assign valid = count_q != 3'd0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (n_push == 2'd2) begin
			mem_q[wr_next] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + n_push;
			rd_q    <= rd_q + {1'b0, pop};
			count_q <= count_q + {1'b0, n_push} - {2'b00, pop};
		end
	end

endmodule

// ----- hdl/amr_bw_efficient_to_octet_aligned_unit.sv -----
// AMR payload converter, bandwidth-efficient to octet-aligned, one byte per word.
// An accepted input word is registered first; its result words then go through the queue.
// Throughput: one input word per cycle while the sink keeps up; a word that yields two
// results puts them out one at a time; input waits while three or more are queued.
// Reset clears all frame state and the queue and sets the output space limit to 256.
module amr_bw_efficient_to_octet_aligned_unit #(
	parameter int BUFFER_BYTES = amr_b2o_pkg::BUFFER_BYTES_DEFAULT
) (
	input  logic   clk,
	input  logic   arst_n,
	amr_b2o_in_if.sink   in_ch,
	amr_b2o_out_if.source out_ch,
	amr_b2o_cfg_if.sink  cfg_ch
);
	import amr_b2o_pkg::*;

	logic       valid_s1;
	logic [7:0] data_byte_s1;
	logic [7:0] frame_length_s1;
	logic       last_byte_s1;
	logic [8:0] osl_q;
	logic       room;
	logic       step;
	logic       pop;
	push_t      push;
	res_t       head;

	assign step         = valid_s1 && room;
	assign in_ch.ready  = !valid_s1 || step;
	assign cfg_ch.ready = 1'b1;
	assign pop          = out_ch.valid && out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			osl_q    <= OSL_RESET;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (cfg_ch.valid) begin
				osl_q <= cfg_ch.output_space_limit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			data_byte_s1    <= in_ch.data_byte;
			frame_length_s1 <= in_ch.frame_length;
			last_byte_s1    <= in_ch.last_byte;
		end
	end

	amr_b2o_conv #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_conv (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.data_byte   (data_byte_s1),
		.frame_length(frame_length_s1),
		.last_byte   (last_byte_s1),
		.osl         (osl_q),
		.push        (push)
	);

	amr_b2o_obuf u_obuf (
		.clk    (clk),
		.arst_n (arst_n),
		.push_en(step),
		.push   (push),
		.pop    (pop),
		.room   (room),
		.valid  (out_ch.valid),
		.head   (head)
	);

	assign out_ch.out_byte      = head.out_byte;
	assign out_ch.out_length    = head.out_length;
	assign out_ch.error         = head.error;
	assign out_ch.last_of_frame = head.last_of_frame;

endmodule

// ----- hdl/amr_b2o_chk.sv -----
// Port-level checker for the converter's result channel, bound to the top level.
// Depends only on the top level's ports.
module amr_b2o_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic [5:0] out_length,
	input logic       error,
	input logic       last_of_frame
);

	// A rejected frame gives a single closing word with no data.
	a_error_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> last_of_frame && out_byte == 8'd0 && out_length == 6'd0)
		else $error("error word carries data or is not last");

	// A good frame always has the two header bytes and at most 31 speech bytes.
	a_good_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !error |-> out_length >= 6'd2 && out_length <= 6'd33)
		else $error("result length out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_length)
			&& $stable(error) && $stable(last_of_frame))
		else $error("stalled result word changed");

endmodule

bind amr_bw_efficient_to_octet_aligned_unit amr_b2o_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_byte     (out_ch.out_byte),
	.out_length   (out_ch.out_length),
	.error        (out_ch.error),
	.last_of_frame(out_ch.last_of_frame)
);

// ----- tb/tb_amr_bw_efficient_to_octet_aligned_unit.sv -----
// Self-checking testbench for the AMR bandwidth-efficient to octet-aligned converter.
// Holds a scoreboard class that predicts the result words and a top module that drives
// the block. Depends on amr_b2o_pkg, the channel interfaces and the converter RTL.
module tb_amr_bw_efficient_to_octet_aligned_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import amr_b2o_pkg::*;

	class octet_frame_scoreboard;
		logic [8:0] space_limit;
		logic [7:0] byte_pos;
		logic [7:0] held_byte;
		logic [3:0] cur_ft;
		logic [5:0] octet_len;
		bit discarding;
		bit frame_done;
		res_t pending_octets[$];
		int failures;

		function new();
			space_limit = OSL_RESET;
			cur_ft = '0;
			octet_len = '0;
			failures = 0;
			restart();
		endfunction

		static function int speech_len(logic [3:0] ft);
			case (ft)
				4'd0: return 95;
				4'd1: return 103;
				4'd2: return 118;
				4'd3: return 134;
				4'd4: return 148;
				4'd5: return 159;
				4'd6: return 204;
				4'd7: return 244;
				4'd8: return 39;
				4'd9: return 43;
				4'd10: return 38;
				4'd11: return 37;
				default: return 0;
			endcase
		endfunction

		function void restart();
			byte_pos = '0;
			held_byte = '0;
			discarding = 0;
			frame_done = 0;
		endfunction

		function void push(logic [7:0] b, logic [5:0] len, bit err, bit last);
			res_t r;
			r.out_byte = b;
			r.out_length = len;
			r.error = err;
			r.last_of_frame = last;
			pending_octets.push_back(r);
		endfunction

		function void reject(bit lb);
			push(8'd0, 6'd0, 1'b1, 1'b1);
			if (lb) begin
				restart();
			end else begin
				discarding = 1;
			end
		endfunction

		function void close_frame(bit lb);
			if (lb) begin
				restart();
			end else begin
				frame_done = 1;
			end
		endfunction

		// Works out the result words caused by one accepted input word.
		function void predict_word(logic [7:0] db, logic [7:0] fl, bit lb);
			int bits;
			int need;
			int pad;
			int flen;
			logic [3:0] ft;
			logic [7:0] mask;
			logic [7:0] merged;
			flen = fl;
			if (discarding || frame_done) begin
				if (lb) begin
					restart();
				end
				return;
			end
			if (byte_pos == 8'd0) begin
				if (lb) begin
					reject(lb);
					return;
				end
				held_byte = db;
				byte_pos = 8'd1;
				return;
			end
			if (byte_pos == 8'd1) begin
				ft = {held_byte[2:0], db[7]};
				bits = speech_len(ft);
				need = (17 + bits) / 8;
				if (flen < 2 || flen + 1 > int'(space_limit) || flen + 1 > BUFFER_BYTES_DEFAULT
						|| (ft > FT_MAX_SPEECH && ft != FT_NO_DATA) || need > flen
						|| (lb && need > 2)) begin
					reject(lb);
					return;
				end
				cur_ft = ft;
				octet_len = 6'(2 + (bits + 7) / 8);
				push(held_byte & 8'hF0, octet_len, 1'b0, 1'b0);
				push({held_byte[3], ft, db[6], 2'b00}, octet_len, 1'b0, need == 2);
				held_byte = db;
				byte_pos = 8'd2;
				if (need == 2) begin
					close_frame(lb);
				end
				return;
			end
			bits = speech_len(cur_ft);
			need = (17 + bits) / 8;
			if (lb && int'(byte_pos) + 1 < need) begin
				reject(lb);
				return;
			end
			pad = ((bits + 7) / 8) * 8 - bits;
			mask = 8'hFF << pad;
			merged = {held_byte[5:0], db[7:6]};
			if (int'(byte_pos) + 1 < need) begin
				push(merged, octet_len, 1'b0, 1'b0);
				held_byte = db;
				if (byte_pos < 8'd255) begin
					byte_pos = byte_pos + 8'd1;
				end
				return;
			end
			// This word carries the last speech bits; with two or more pad bits the
			// final octet needs nothing from a further word.
			if (pad >= 2) begin
				push(merged, octet_len, 1'b0, 1'b0);
				push({db[5:0], 2'b00} & mask, octet_len, 1'b0, 1'b1);
			end else begin
				push(merged & mask, octet_len, 1'b0, 1'b1);
			end
			close_frame(lb);
		endfunction

		function void check_octet(res_t got);
			res_t want;
			if (pending_octets.size() == 0) begin
				$error("unexpected result word: out_byte %0d error %0d", got.out_byte,
					got.error);
				failures++;
				return;
			end
			want = pending_octets.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte mismatch: expected %0d, actual %0d", want.out_byte,
					got.out_byte);
				failures++;
			end
			if (got.out_length !== want.out_length) begin
				$error("out_length mismatch: expected %0d, actual %0d", want.out_length,
					got.out_length);
				failures++;
			end
			if (got.error !== want.error) begin
				$error("error mismatch: expected %0d, actual %0d", want.error, got.error);
				failures++;
			end
			if (got.last_of_frame !== want.last_of_frame) begin
				$error("last_of_frame mismatch: expected %0d, actual %0d",
					want.last_of_frame, got.last_of_frame);
				failures++;
			end
		endfunction
	endclass

	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASE_WORDS = 225;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 8;

	logic clk;
	logic arst_n;
	int cycles;
	int words_sent;
	bit in_steady;
	bit out_steady;
	bit hold_pending;
	logic [7:0] frame_buf [0:255];
	octet_frame_scoreboard sb;

	amr_b2o_in_if in_ch();
	amr_b2o_out_if out_ch();
	amr_b2o_cfg_if cfg_ch();

	amr_bw_efficient_to_octet_aligned_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_ch(cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Mostly back-to-back, a few short pauses and now and then a long one.
	function automatic int pick_gap(bit steady);
		int r;
		if (steady) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 2);
		end else if (r < 95) begin
			return $urandom_range(3, 6);
		end
		return $urandom_range(15, 40);
	endfunction

	always @(posedge clk) begin
		res_t got;
		if (arst_n) begin
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
				got.out_byte = out_ch.out_byte;
				got.out_length = out_ch.out_length;
				got.error = out_ch.error;
				got.last_of_frame = out_ch.last_of_frame;
				sb.check_octet(got);
			end
			if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
				sb.predict_word(in_ch.data_byte, in_ch.frame_length, in_ch.last_byte);
			end
		end
	end

	// Result receiver; once asked, it holds off long enough for the block to fill up.
	initial begin
		int g;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_pending) begin
				hold_pending = 0;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
			g = pick_gap(out_steady);
			if (g > 0) begin
				out_ch.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	end

	task automatic send_word(logic [7:0] db, logic [7:0] fl, bit lb);
		int g;
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= db;
		in_ch.frame_length <= fl;
		in_ch.last_byte <= lb;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		words_sent++;
		g = pick_gap(in_steady);
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// Fills the frame buffer and places the frame type in the header bits.
	task automatic fill_frame(logic [3:0] ft, int pattern);
		for (int i = 0; i < 256; i++) begin
			frame_buf[i] = (pattern < 0) ? 8'($urandom) : 8'(pattern);
		end
		frame_buf[0][2:0] = ft[3:1];
		frame_buf[1][7] = ft[0];
	endtask

	task automatic send_frame(int flen, int count);
		for (int i = 0; i < count; i++) begin
			send_word(frame_buf[i], 8'(flen), i == count - 1);
		end
	endtask

	task automatic random_frame();
		int r;
		int need;
		int flen;
		int count;
		logic [3:0] ft;
		r = $urandom_range(0, 99);
		if (r < 88) begin
			ft = 4'($urandom_range(0, 12));
			if (ft > FT_MAX_SPEECH) begin
				ft = FT_NO_DATA;
			end
		end else begin
			ft = 4'($urandom_range(12, 14));
		end
		need = (17 + int'(speech_bits(ft))) / 8;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			flen = need + $urandom_range(0, 3);
		end else if (r < 88) begin
			flen = $urandom_range(need, 255);
		end else if (r < 94) begin
			flen = $urandom_range(0, need - 1);
		end else begin
			flen = $urandom_range(0, 255);
		end
		r = $urandom_range(0, 99);
		if (r < 80) begin
			count = need + $urandom_range(0, 2);
		end else if (r < 92) begin
			count = $urandom_range(1, need);
		end else begin
			count = $urandom_range(1, 3);
		end
		fill_frame(ft, -1);
		send_frame(flen, count);
	endtask

	// Lets the block drain; words that give no result may still be in flight.
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (sb.pending_octets.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_space_limit(logic [8:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.output_space_limit <= value;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		sb.space_limit = value;
	endtask

	initial begin
		logic [8:0] limits [0:5];
		int start;
		sb = new();
		cycles = 0;
		words_sent = 0;
		in_steady = 0;
		out_steady = 0;
		hold_pending = 0;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.data_byte <= 8'd0;
		in_ch.frame_length <= 8'd0;
		in_ch.last_byte <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.output_space_limit <= 9'd0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// No-data frame: only the two header octets.
		fill_frame(FT_NO_DATA, -1);
		send_frame(2, 2);
		// Last byte on the very first word.
		fill_frame(4'd8, -1);
		send_frame(0, 1);
		// Reserved frame type.
		fill_frame(4'd13, -1);
		send_frame(2, 2);
		// Frame length below two, then a trailing word that is ignored.
		fill_frame(4'd8, 0);
		send_frame(1, 3);
		// Frame length too short for the speech bits.
		fill_frame(4'd8, -1);
		send_frame(6, 3);
		// Frame that ends before its speech bits are complete.
		fill_frame(4'd11, -1);
		send_frame(6, 4);
		// Two pad bits: the final octet comes with the one before it, and the
		// trailing words after the needed span give nothing.
		fill_frame(4'd10, 255);
		send_frame(255, 8);
		wait_idle();

		limits[0] = 9'd256;
		limits[1] = 9'd0;
		limits[2] = 9'd18;
		limits[3] = 9'd33;
		limits[4] = 9'($urandom_range(0, 256));
		limits[5] = 9'd256;
		for (int p = 0; p < 6; p++) begin
			write_space_limit(limits[p]);
			in_steady = (p == 1) || (p == 3);
			out_steady = (p == 1);
			hold_pending = (p == 3);
			start = words_sent;
			while (words_sent - start < PHASE_WORDS) begin
				random_frame();
			end
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (sb.failures == 0 && sb.pending_octets.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

// ----- sim.f -----
hdl/amr_b2o_pkg.sv
hdl/amr_b2o_if.sv
hdl/amr_b2o_conv.sv
hdl/amr_b2o_obuf.sv
hdl/amr_bw_efficient_to_octet_aligned_unit.sv
hdl/amr_b2o_chk.sv
tb/tb_amr_bw_efficient_to_octet_aligned_unit.sv
